// ===== src/sbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsm_pkg - shared types and constants of the bank switch mapper
// Bus operation codes, target codes, item classes and the beat formats
// that travel between the front and back parts.
// ----------------------------------------------------------------------------
package sbsm_pkg;

	localparam int SAVE_RAM_BYTES = 8192;
	localparam int SAVE_ADDR_BITS = $clog2(SAVE_RAM_BYTES);

	localparam logic [15:0] SAVE_RAM_BASE = 16'h6000;
	localparam logic [15:0] PROGRAM_BASE  = 16'h8000;
	localparam logic [15:0] UPPER_BASE    = 16'hC000;

	localparam logic [4:0] SHIFT_MARKER   = 5'b10000;
	localparam logic [4:0] MODE_FIX_LAST  = 5'h0C;
	localparam logic [3:0] PROGRAM_EVEN   = 4'hE;
	localparam logic [4:0] PATTERN_EVEN   = 5'h1E;

	localparam logic [1:0] OP_PROGRAM_READ  = 2'd0;
	localparam logic [1:0] OP_PROGRAM_WRITE = 2'd1;
	localparam logic [1:0] OP_PATTERN_READ  = 2'd2;
	localparam logic [1:0] OP_PATTERN_WRITE = 2'd3;

	localparam logic [1:0] TARGET_NONE     = 2'd0;
	localparam logic [1:0] TARGET_SAVE_RAM = 2'd1;
	localparam logic [1:0] TARGET_PROGRAM  = 2'd2;
	localparam logic [1:0] TARGET_PATTERN  = 2'd3;

	localparam logic [1:0] CFG_LAST_PROGRAM_BANK = 2'd0;
	localparam logic [1:0] CFG_LAST_PATTERN_BANK = 2'd1;
	localparam logic [1:0] CFG_SAVE_RAM_PRESENT  = 2'd2;

	localparam logic [1:0] SEL_CONTROL      = 2'd0;
	localparam logic [1:0] SEL_PATTERN_LOW  = 2'd1;
	localparam logic [1:0] SEL_PATTERN_HIGH = 2'd2;
	localparam logic [1:0] SEL_PROGRAM      = 2'd3;

	localparam logic [1:0] PMODE_FIX_FIRST = 2'd2;

	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_SAVE_RAM  = 3'd1,
		KIND_PROG_READ = 3'd2,
		KIND_SERIAL    = 3'd3,
		KIND_PATTERN   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        is_write;
		logic [15:0] addr;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic [3:0] last_program_bank;
		logic [4:0] last_pattern_bank;
	} bank_cfg_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [17:0] memory_address;
		logic        write_enable;
		logic [7:0]  byte_out;
		logic        vertical_mirroring;
	} result_t;

endpackage

// ===== src/sbsm_front.sv =====
// ----------------------------------------------------------------------------
// sbsm_front - access intake and classification
// Accepts bus beats, sorts each into its kind of access and holds the
// classified items in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module sbsm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          op,
	input  logic [15:0]         bus_address,
	input  logic [7:0]          write_byte,
	input  logic                save_ram_present,
	output logic                item_valid,
	output sbsm_pkg::item_t     item,
	input  logic                item_take
);

	sbsm_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	sbsm_pkg::item_t incoming;
	logic            program_side;
	logic            accept;

	always_comb begin
		program_side = (op == sbsm_pkg::OP_PROGRAM_READ) || (op == sbsm_pkg::OP_PROGRAM_WRITE);
		incoming.is_write = (op == sbsm_pkg::OP_PROGRAM_WRITE) ||
			(op == sbsm_pkg::OP_PATTERN_WRITE);
		incoming.addr = bus_address;
		incoming.data = write_byte;
		if (!program_side) begin
			incoming.kind = sbsm_pkg::KIND_PATTERN;
		end else if (bus_address >= sbsm_pkg::PROGRAM_BASE) begin
			incoming.kind = incoming.is_write ? sbsm_pkg::KIND_SERIAL : sbsm_pkg::KIND_PROG_READ;
		end else if (bus_address >= sbsm_pkg::SAVE_RAM_BASE && save_ram_present) begin
			incoming.kind = sbsm_pkg::KIND_SAVE_RAM;
		end else begin
			incoming.kind = sbsm_pkg::KIND_NONE;
		end
	end

	assign full       = (count_q == 2'd2);
	assign accept     = push && !full;
	assign item_valid = (count_q != 2'd0);
	assign item       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(accept) - 2'(item_take);
		end
	end

endmodule

// ===== src/sbsm_back.sv =====
// ----------------------------------------------------------------------------
// sbsm_back - serial loader, bank maps and address translation
// Takes classified items in order, runs the five-beat serial load and the
// bank remap, translates each access and queues the results.
// ----------------------------------------------------------------------------
module sbsm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbsm_pkg::bank_cfg_t  cfg,
	input  logic                 item_valid,
	input  sbsm_pkg::item_t      item,
	output logic                 item_take,
	output logic                 empty,
	input  logic                 pop,
	output sbsm_pkg::result_t    result
);

	logic [4:0] shift_q;
	logic [4:0] control_q;
	logic [4:0] pattern_low_q;
	logic [4:0] pattern_high_q;
	logic [4:0] program_q;
	logic [3:0] program_map_q [2];
	logic [4:0] pattern_map_q [2];

	logic [4:0] shift_n;
	logic [4:0] control_n;
	logic [4:0] pattern_low_n;
	logic [4:0] pattern_high_n;
	logic [4:0] program_n;
	logic [4:0] shifted;
	logic       remap_en;
	logic [3:0] program_map_n [2];
	logic [4:0] pattern_map_n [2];
	logic [3:0] lp_less;
	logic [4:0] lc_less;
	logic [3:0] pb;
	logic [3:0] pb_even;
	logic [4:0] pc_even;
	logic       serial_beat;

	sbsm_pkg::result_t res;
	sbsm_pkg::result_t out_q [2];
	logic              out_wr_q;
	logic              out_rd_q;
	logic [1:0]        out_count_q;

	assign item_take   = item_valid && (out_count_q != 2'd2);
	assign serial_beat = item_take && (item.kind == sbsm_pkg::KIND_SERIAL);
	assign shifted     = {item.data[0], shift_q[4:1]};

	always_comb begin
		shift_n        = shift_q;
		control_n      = control_q;
		pattern_low_n  = pattern_low_q;
		pattern_high_n = pattern_high_q;
		program_n      = program_q;
		remap_en       = 1'b0;
		if (serial_beat) begin
			if (item.data[7]) begin
				shift_n   = sbsm_pkg::SHIFT_MARKER;
				control_n = control_q | sbsm_pkg::MODE_FIX_LAST;
				remap_en  = 1'b1;
			end else if (shift_q[0]) begin
				shift_n  = sbsm_pkg::SHIFT_MARKER;
				remap_en = 1'b1;
				case (item.addr[14:13])
					sbsm_pkg::SEL_CONTROL:      control_n      = shifted;
					sbsm_pkg::SEL_PATTERN_LOW:  pattern_low_n  = shifted;
					sbsm_pkg::SEL_PATTERN_HIGH: pattern_high_n = shifted;
					default:                    program_n      = shifted;
				endcase
			end else begin
				shift_n = shifted;
			end
		end
	end

	always_comb begin
		lp_less = (cfg.last_program_bank == 4'd0) ? 4'd0 : cfg.last_program_bank - 4'd1;
		lc_less = (cfg.last_pattern_bank == 5'd0) ? 5'd0 : cfg.last_pattern_bank - 5'd1;
		pb      = program_n[3:0];
		pb_even = pb & sbsm_pkg::PROGRAM_EVEN;
		pc_even = pattern_low_n & sbsm_pkg::PATTERN_EVEN;

		if (control_n[3:2] < sbsm_pkg::PMODE_FIX_FIRST) begin
			program_map_n[0] = (pb_even < lp_less) ? pb_even : lp_less;
			program_map_n[1] = program_map_n[0] + 4'd1;
		end else if (control_n[3:2] == sbsm_pkg::PMODE_FIX_FIRST) begin
			program_map_n[0] = 4'd0;
			program_map_n[1] = (pb < cfg.last_program_bank) ? pb : cfg.last_program_bank;
		end else begin
			program_map_n[0] = (pb < cfg.last_program_bank) ? pb : cfg.last_program_bank;
			program_map_n[1] = cfg.last_program_bank;
		end

		if (!control_n[4]) begin
			pattern_map_n[0] = (pc_even < lc_less) ? pc_even : lc_less;
			pattern_map_n[1] = pattern_map_n[0] + 5'd1;
		end else begin
			pattern_map_n[0] = (pattern_low_n < cfg.last_pattern_bank) ?
				pattern_low_n : cfg.last_pattern_bank;
			pattern_map_n[1] = (pattern_high_n < cfg.last_pattern_bank) ?
				pattern_high_n : cfg.last_pattern_bank;
		end
	end

	always_comb begin
		res.target             = sbsm_pkg::TARGET_NONE;
		res.memory_address     = 18'd0;
		res.write_enable       = 1'b0;
		res.byte_out           = 8'd0;
		res.vertical_mirroring = ~control_n[0];
		case (item.kind)
			sbsm_pkg::KIND_SAVE_RAM: begin
				res.target         = sbsm_pkg::TARGET_SAVE_RAM;
				res.memory_address = 18'(item.addr[sbsm_pkg::SAVE_ADDR_BITS-1:0]);
				res.write_enable   = item.is_write;
			end
			sbsm_pkg::KIND_PROG_READ: begin
				res.target         = sbsm_pkg::TARGET_PROGRAM;
				res.memory_address = {program_map_q[item.addr >= sbsm_pkg::UPPER_BASE],
					item.addr[13:0]};
			end
			sbsm_pkg::KIND_PATTERN: begin
				res.target         = sbsm_pkg::TARGET_PATTERN;
				res.memory_address = 18'({pattern_map_q[item.addr[12]], item.addr[11:0]});
				res.write_enable   = item.is_write;
			end
			default: begin
				res.target = sbsm_pkg::TARGET_NONE;
			end
		endcase
		if (res.write_enable) begin
			res.byte_out = item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q          <= sbsm_pkg::SHIFT_MARKER;
			control_q        <= 5'd0;
			pattern_low_q    <= 5'd0;
			pattern_high_q   <= 5'd0;
			program_q        <= 5'd0;
			program_map_q[0] <= 4'd0;
			program_map_q[1] <= 4'd1;
			pattern_map_q[0] <= 5'd0;
			pattern_map_q[1] <= 5'd1;
		end else begin
			shift_q        <= shift_n;
			control_q      <= control_n;
			pattern_low_q  <= pattern_low_n;
			pattern_high_q <= pattern_high_n;
			program_q      <= program_n;
			if (remap_en) begin
				program_map_q <= program_map_n;
				pattern_map_q <= pattern_map_n;
			end
		end
	end

	assign empty  = (out_count_q == 2'd0);
	assign result = out_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (item_take) begin
			out_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q    <= 1'b0;
			out_rd_q    <= 1'b0;
			out_count_q <= 2'd0;
		end else begin
			if (item_take) begin
				out_wr_q <= ~out_wr_q;
			end
			if (pop && !empty) begin
				out_rd_q <= ~out_rd_q;
			end
			out_count_q <= out_count_q + 2'(item_take) - 2'(pop && !empty);
		end
	end

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_count_q != 2'd3)
		else $error("result queue overfilled");

	a_load_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		serial_beat && (item.data[7] || shift_q[0]) |=> shift_q == sbsm_pkg::SHIFT_MARKER)
		else $error("shift register not rearmed after load or clear");

	a_clear_mode: assert property (@(posedge clk) disable iff (!arst_n)
		serial_beat && item.data[7] |=> control_q[3:2] == 2'b11)
		else $error("clear beat did not force program mode");

	a_marker_kept: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q != 5'd0)
		else $error("shift register lost its marker");

endmodule

// ===== src/serial_loaded_bank_switch_mapper.sv =====
// ----------------------------------------------------------------------------
// serial_loaded_bank_switch_mapper - serially loaded bank switch mapper
// Translates CPU program and PPU pattern accesses into save RAM, program
// ROM and pattern memory addresses, with a five-beat serial register port.
// ----------------------------------------------------------------------------
// One access is taken per cycle while full is low, and one result comes
// out per access, in order. An access waits in the intake queue, is then
// translated and registered in the result queue, and can then be popped.
// The serial shift, register load and bank remap all finish when the back
// part takes the beat, so a bank write affects the very next access.
// Each side has a two-entry queue; full rises only after results have been
// held back long enough to fill both queues.
// ----------------------------------------------------------------------------
module serial_loaded_bank_switch_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  target,
	output logic [17:0] memory_address,
	output logic        write_enable,
	output logic [7:0]  byte_out,
	output logic        vertical_mirroring,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	logic [3:0]          last_program_bank_q;
	logic [4:0]          last_pattern_bank_q;
	logic                save_ram_present_q;
	sbsm_pkg::bank_cfg_t bank_cfg;
	sbsm_pkg::item_t     item;
	logic                item_valid;
	logic                item_take;
	sbsm_pkg::result_t   result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_program_bank_q <= 4'd1;
			last_pattern_bank_q <= 5'd1;
			save_ram_present_q  <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				sbsm_pkg::CFG_LAST_PROGRAM_BANK: last_program_bank_q <= cfg_data[3:0];
				sbsm_pkg::CFG_LAST_PATTERN_BANK: last_pattern_bank_q <= cfg_data;
				sbsm_pkg::CFG_SAVE_RAM_PRESENT:  save_ram_present_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign bank_cfg.last_program_bank = last_program_bank_q;
	assign bank_cfg.last_pattern_bank = last_pattern_bank_q;

	sbsm_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.op               (op),
		.bus_address      (bus_address),
		.write_byte       (write_byte),
		.save_ram_present (save_ram_present_q),
		.item_valid       (item_valid),
		.item             (item),
		.item_take        (item_take)
	);

	sbsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (bank_cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	assign target             = result.target;
	assign memory_address     = result.memory_address;
	assign write_enable       = result.write_enable;
	assign byte_out           = result.byte_out;
	assign vertical_mirroring = result.vertical_mirroring;

endmodule
